FILE: rtl/mma_pkg.sv
// mma_pkg: shared types, constants and helpers for the matrix multiply-accumulate block.
// Used by mma_mac, matrix_multiply_accumulate and mma_check. No dependencies.

package mma_pkg;

    // Matrix geometry
    localparam int MAX_DIM     = 16;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int FRAC_W      = 16;

    // Opcodes
    localparam logic [2:0] OP_LOAD_A   = 3'd0;
    localparam logic [2:0] OP_LOAD_B   = 3'd1;
    localparam logic [2:0] OP_LOAD_OUT = 3'd2;
    localparam logic [2:0] OP_MULTIPLY = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'b00;
    localparam logic [1:0] ST_INNER = 2'b01;
    localparam logic [1:0] ST_SHAPE = 2'b10;
    localparam logic [1:0] ST_RANGE = 2'b11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS = 3'd5;

    // Saturation limits
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]               opcode;
        logic [7:0]               elem_index;
        logic signed [DATA_W-1:0] elem_value;
        logic                     flip_a;
        logic                     flip_b;
        logic                     clear_first;
    } req_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
    } rsp_item_t;

    // Control from the sequencer to the MAC unit
    typedef struct packed {
        logic acc_load;
        logic op_valid;
    } mac_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_OUT_RD,
        S_ISSUE,
        S_DRAIN,
        S_DONE
    } state_t;

    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        return (d != '0) && (d <= DIM_W'(MAX_DIM));
    endfunction

endpackage

FILE: rtl/mma_mac.sv
// mma_mac: shared Q16.16 multiply-accumulate unit, multiply then saturating add.
// Depends on mma_pkg.

module mma_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mma_pkg::mac_ctrl_t               ctrl,
    input  logic signed [mma_pkg::DATA_W-1:0] init_value,
    input  logic signed [mma_pkg::DATA_W-1:0] a_value,
    input  logic signed [mma_pkg::DATA_W-1:0] b_value,
    output logic signed [mma_pkg::DATA_W-1:0] acc_value,
    output logic                             busy
);

    localparam int SUM_W = mma_pkg::PROD_W - mma_pkg::FRAC_W + 1;

    logic                               p_vld_reg;
    logic signed [mma_pkg::PROD_W-1:0]  prod_reg;
    logic signed [mma_pkg::DATA_W-1:0]  acc_reg;
    logic signed [mma_pkg::DATA_W-1:0]  acc_next;
    logic signed [SUM_W-2:0]            prod_q;
    logic signed [SUM_W-1:0]            sum;

    // Product valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= ctrl.op_valid;
        end
    end

    // Full-width product stage
    always_ff @(posedge clk)
    begin
        if (ctrl.op_valid)
        begin
            prod_reg <= a_value * b_value;
        end
    end

    // Floor back to Q16.16 (arithmetic shift), add, saturate
    always_comb
    begin
        prod_q = prod_reg[mma_pkg::PROD_W-1:mma_pkg::FRAC_W];
        sum    = {{(SUM_W-mma_pkg::DATA_W){acc_reg[mma_pkg::DATA_W-1]}}, acc_reg}
                 + {prod_q[SUM_W-2], prod_q};
        if (sum[SUM_W-1:mma_pkg::DATA_W-1] == '0 || sum[SUM_W-1:mma_pkg::DATA_W-1] == '1)
        begin
            acc_next = sum[mma_pkg::DATA_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            acc_next = mma_pkg::Q_MIN;
        end
        else
        begin
            acc_next = mma_pkg::Q_MAX;
        end
    end

    // Accumulator
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_load)
        begin
            acc_reg <= init_value;
        end
        else if (p_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_value = acc_reg;
    assign busy      = p_vld_reg;

endmodule

FILE: rtl/matrix_multiply_accumulate.sv
// Matrix multiply-accumulate, signed Q16.16, with stores for A, B and the output.
// Depends on mma_pkg and mma_mac.
// Flow: the item is registered, then decoded (loads write, failed checks end there); a read
// adds a registered store read. Multiply: R x C output, inner size K; per element the output
// element is read, K MACs issue one per cycle through the shared multiplier, then it drains.
// One item at a time; the next item is accepted the cycle after its result is registered.
// Reset: dimension registers go to 1, output store reads as zero at once (valid bits).

module matrix_multiply_accumulate (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  mma_pkg::req_item_t              req_item,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output mma_pkg::rsp_item_t              rsp_item,
    input  logic                            cfg_we,
    input  logic [mma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mma_pkg::DIM_W-1:0]       cfg_data
);

    localparam int AW  = mma_pkg::ADDR_W;
    localparam int IW  = mma_pkg::IDX_W;
    localparam int DW  = mma_pkg::DIM_W;
    localparam int QW  = mma_pkg::DATA_W;
    localparam int MW  = 2 * DW;

    // Configuration registers
    logic [DW-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [DW-1:0] o_rows_reg, o_cols_reg;

    // Sequencer state
    mma_pkg::state_t    state_reg, state_next;
    mma_pkg::req_item_t item_reg;
    logic [IW-1:0]      i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [DW-1:0]      mrows_reg, mcols_reg, minner_reg;
    logic [1:0]         res_status_reg, res_status_next;
    logic signed [QW-1:0] res_value_reg, res_value_next;

    // Output register
    logic               rsp_valid_reg;
    mma_pkg::rsp_item_t rsp_item_reg;

    // Stores
    logic signed [QW-1:0] a_store_reg [mma_pkg::STORE_DEPTH];
    logic signed [QW-1:0] b_store_reg [mma_pkg::STORE_DEPTH];
    logic signed [QW-1:0] out_store_reg [mma_pkg::STORE_DEPTH];
    logic [mma_pkg::STORE_DEPTH-1:0] o_valid_reg;
    logic signed [QW-1:0] a_rdata_reg, b_rdata_reg, o_rdata_reg;
    logic                 o_rvld_reg;
    logic                 rd_vld_reg;

    // Strobes and addresses
    logic               accept, push, start_mul;
    logic               a_we, b_we, o_we, o_clr, issue, res_load;
    logic [AW-1:0]      a_raddr, b_raddr, o_raddr, o_waddr, oi;
    logic signed [QW-1:0] o_wdata;
    mma_pkg::mac_ctrl_t mac_ctrl;
    logic signed [QW-1:0] acc_value;
    logic               mac_busy;

    // Decode-time checks
    logic [DW-1:0]      sel_rows, sel_cols, ar, ac, br, bc;
    logic [MW-1:0]      sel_size;
    logic               in_range, dims_all_ok;
    logic [1:0]         dec_status;
    logic               i_last, j_last, k_last;
    logic [MW-1:0]      oi_w, ai_w, bi_w;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != mma_pkg::S_IDLE);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DW'(1);
            a_cols_reg <= DW'(1);
            b_rows_reg <= DW'(1);
            b_cols_reg <= DW'(1);
            o_rows_reg <= DW'(1);
            o_cols_reg <= DW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mma_pkg::CFG_A_ROWS:   a_rows_reg <= cfg_data;
                mma_pkg::CFG_A_COLS:   a_cols_reg <= cfg_data;
                mma_pkg::CFG_B_ROWS:   b_rows_reg <= cfg_data;
                mma_pkg::CFG_B_COLS:   b_cols_reg <= cfg_data;
                mma_pkg::CFG_OUT_ROWS: o_rows_reg <= cfg_data;
                mma_pkg::CFG_OUT_COLS: o_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Item checks: target dims, index range, multiply shapes
    always_comb
    begin
        case (item_reg.opcode)
            mma_pkg::OP_LOAD_A:
            begin
                sel_rows = a_rows_reg;
                sel_cols = a_cols_reg;
            end
            mma_pkg::OP_LOAD_B:
            begin
                sel_rows = b_rows_reg;
                sel_cols = b_cols_reg;
            end
            default:
            begin
                sel_rows = o_rows_reg;
                sel_cols = o_cols_reg;
            end
        endcase
        sel_size = MW'(sel_rows) * MW'(sel_cols);
        in_range = mma_pkg::dim_ok(sel_rows) && mma_pkg::dim_ok(sel_cols)
                   && (MW'(item_reg.elem_index) < sel_size);

        dims_all_ok = mma_pkg::dim_ok(a_rows_reg) && mma_pkg::dim_ok(a_cols_reg)
                      && mma_pkg::dim_ok(b_rows_reg) && mma_pkg::dim_ok(b_cols_reg)
                      && mma_pkg::dim_ok(o_rows_reg) && mma_pkg::dim_ok(o_cols_reg);
        ar = item_reg.flip_a ? a_cols_reg : a_rows_reg;
        ac = item_reg.flip_a ? a_rows_reg : a_cols_reg;
        br = item_reg.flip_b ? b_cols_reg : b_rows_reg;
        bc = item_reg.flip_b ? b_rows_reg : b_cols_reg;

        case (item_reg.opcode)
            mma_pkg::OP_LOAD_A, mma_pkg::OP_LOAD_B, mma_pkg::OP_LOAD_OUT, mma_pkg::OP_READ:
                dec_status = in_range ? mma_pkg::ST_OK : mma_pkg::ST_RANGE;
            mma_pkg::OP_MULTIPLY:
            begin
                if (!dims_all_ok)
                    dec_status = mma_pkg::ST_RANGE;
                else if (ac != br)
                    dec_status = mma_pkg::ST_INNER;
                else if (o_rows_reg != ar || o_cols_reg != bc)
                    dec_status = mma_pkg::ST_SHAPE;
                else
                    dec_status = mma_pkg::ST_OK;
            end
            default:
                dec_status = mma_pkg::ST_OK;
        endcase
    end

    // Element addresses from loop counters
    always_comb
    begin
        i_last = (DW'(i_reg) + DW'(1)) == mrows_reg;
        j_last = (DW'(j_reg) + DW'(1)) == mcols_reg;
        k_last = (DW'(k_reg) + DW'(1)) == minner_reg;
        oi_w = MW'(i_reg) * MW'(mcols_reg) + MW'(j_reg);
        ai_w = item_reg.flip_a ? (MW'(k_reg) * MW'(a_cols_reg) + MW'(i_reg))
                               : (MW'(i_reg) * MW'(a_cols_reg) + MW'(k_reg));
        bi_w = item_reg.flip_b ? (MW'(j_reg) * MW'(b_cols_reg) + MW'(k_reg))
                               : (MW'(k_reg) * MW'(b_cols_reg) + MW'(j_reg));
        oi      = oi_w[AW-1:0];
        a_raddr = ai_w[AW-1:0];
        b_raddr = bi_w[AW-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mma_pkg::S_IDLE:
                if (accept)
                    state_next = mma_pkg::S_DECODE;
            mma_pkg::S_DECODE:
            begin
                if (dec_status != mma_pkg::ST_OK)
                    state_next = mma_pkg::S_DONE;
                else if (item_reg.opcode == mma_pkg::OP_READ)
                    state_next = mma_pkg::S_READ;
                else if (item_reg.opcode == mma_pkg::OP_MULTIPLY)
                    state_next = mma_pkg::S_OUT_RD;
                else
                    state_next = mma_pkg::S_DONE;
            end
            mma_pkg::S_READ:
                state_next = mma_pkg::S_DONE;
            mma_pkg::S_OUT_RD:
                state_next = mma_pkg::S_ISSUE;
            mma_pkg::S_ISSUE:
                if (k_last)
                    state_next = mma_pkg::S_DRAIN;
            mma_pkg::S_DRAIN:
                if (!rd_vld_reg && !mac_busy)
                    state_next = (i_last && j_last) ? mma_pkg::S_DONE : mma_pkg::S_OUT_RD;
            mma_pkg::S_DONE:
                if (push)
                    state_next = mma_pkg::S_IDLE;
            default:
                state_next = mma_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: strobes, counters, result
    always_comb
    begin
        a_we            = 1'b0;
        b_we            = 1'b0;
        o_we            = 1'b0;
        o_clr           = 1'b0;
        issue           = 1'b0;
        start_mul       = 1'b0;
        res_load        = 1'b0;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        mac_ctrl        = '0;
        push            = 1'b0;
        o_raddr         = item_reg.elem_index;
        o_waddr         = item_reg.elem_index;
        o_wdata         = item_reg.elem_value;
        case (state_reg)
            mma_pkg::S_DECODE:
            begin
                res_load        = 1'b1;
                res_status_next = dec_status;
                res_value_next  = '0;
                if (dec_status == mma_pkg::ST_OK)
                begin
                    a_we = (item_reg.opcode == mma_pkg::OP_LOAD_A);
                    b_we = (item_reg.opcode == mma_pkg::OP_LOAD_B);
                    o_we = (item_reg.opcode == mma_pkg::OP_LOAD_OUT);
                    if (item_reg.opcode == mma_pkg::OP_MULTIPLY)
                    begin
                        start_mul = 1'b1;
                        o_clr     = item_reg.clear_first;
                        i_next    = '0;
                        j_next    = '0;
                        k_next    = '0;
                    end
                end
            end
            mma_pkg::S_READ:
            begin
                res_load       = 1'b1;
                res_value_next = o_rvld_reg ? o_rdata_reg : '0;
            end
            mma_pkg::S_OUT_RD:
            begin
                o_raddr = oi;
                k_next  = '0;
            end
            mma_pkg::S_ISSUE:
            begin
                issue             = 1'b1;
                mac_ctrl.acc_load = (k_reg == '0);
                k_next            = k_reg + IW'(1);
            end
            mma_pkg::S_DRAIN:
            begin
                if (!rd_vld_reg && !mac_busy)
                begin
                    o_we    = 1'b1;
                    o_waddr = oi;
                    o_wdata = acc_value;
                    if (j_last)
                    begin
                        j_next = '0;
                        i_next = i_reg + IW'(1);
                    end
                    else
                    begin
                        j_next = j_reg + IW'(1);
                    end
                end
            end
            mma_pkg::S_DONE:
                push = !rsp_valid_reg || !rsp_stall;
            default: ;
        endcase
        mac_ctrl.op_valid = rd_vld_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mma_pkg::S_IDLE;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
        end
    end

    // Item, counters, result
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req_item;
        if (start_mul)
        begin
            mrows_reg  <= ar;
            mcols_reg  <= bc;
            minner_reg <= ac;
        end
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rsp_item_reg.status     <= res_status_reg;
            rsp_item_reg.read_value <= res_value_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // Output store valid bits: cleared by reset and by clear-first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= '0;
        end
        else if (o_clr)
        begin
            o_valid_reg <= '0;
        end
        else if (o_we)
        begin
            o_valid_reg[o_waddr] <= 1'b1;
        end
    end

    // Store writes
    always_ff @(posedge clk)
    begin
        if (a_we)
            a_store_reg[item_reg.elem_index] <= item_reg.elem_value;
        if (b_we)
            b_store_reg[item_reg.elem_index] <= item_reg.elem_value;
        if (o_we)
            out_store_reg[o_waddr] <= o_wdata;
    end

    // Registered store reads
    always_ff @(posedge clk)
    begin
        a_rdata_reg <= a_store_reg[a_raddr];
        b_rdata_reg <= b_store_reg[b_raddr];
        o_rdata_reg <= out_store_reg[o_raddr];
        o_rvld_reg  <= o_valid_reg[o_raddr];
    end

    // Shared MAC; accumulator starts from the stored output element
    mma_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .init_value (o_rvld_reg ? o_rdata_reg : '0),
        .a_value    (a_rdata_reg),
        .b_value    (b_rdata_reg),
        .acc_value  (acc_value),
        .busy       (mac_busy)
    );

endmodule

FILE: rtl/mma_check.sv
// mma_check: port-level checks for matrix_multiply_accumulate, bound to the top level.
// Depends on mma_pkg.

module mma_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input mma_pkg::req_item_t            req_item,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input mma_pkg::rsp_item_t            rsp_item
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("stalled result item changed");

    // A stalled input item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_item))
        else $error("stalled input item changed");

    // Block takes one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("item accepted while previous item in work");

    // A new result only appears while an item is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result item without an item in work");

    // Read value is zero on any failure status
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.status == mma_pkg::ST_OK || rsp_item.read_value == '0))
        else $error("nonzero read value on failed item");

endmodule

bind matrix_multiply_accumulate mma_check u_mma_check (.*);

FILE: verif/matrix_multiply_accumulate_tb.sv
// Self-checking testbench for matrix_multiply_accumulate: loads, reads and GEMM items
// checked against a Q16.16 shadow of the three stores and the six dimension registers.
// Depends on mma_pkg and the block's RTL.

module matrix_multiply_accumulate_tb;

    import mma_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int CLK_PERIOD     = 2 * CLK_HALF;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 10;
    localparam int ITEM_TARGET    = 950;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    // Opcodes the block ignores
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // Shadow of the block: stores, dimension registers and the results still owed
    class gemm_tracker;
        logic signed [DATA_W-1:0] a_mat [STORE_DEPTH];
        logic signed [DATA_W-1:0] b_mat [STORE_DEPTH];
        logic signed [DATA_W-1:0] c_mat [STORE_DEPTH];
        logic [DIM_W-1:0]         dim [6];
        rsp_item_t                pending_results [$];
        int                       failures;

        function new();
            foreach (c_mat[n])
            begin
                a_mat[n] = '0;
                b_mat[n] = '0;
                c_mat[n] = '0;
            end
            foreach (dim[n])
                dim[n] = DIM_W'(1);
            failures = 0;
        endfunction

        function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
            dim[idx] = value;
        endfunction

        function bit is_legal_dim(logic [DIM_W-1:0] d);
            return d >= 1 && d <= MAX_DIM;
        endfunction

        function bit shape_legal();
            foreach (dim[n])
                if (!is_legal_dim(dim[n]))
                    return 1'b0;
            return 1'b1;
        endfunction

        // Number of addressable elements for a load or read; zero if the shape is illegal
        function int extent(logic [2:0] op);
            logic [DIM_W-1:0] r;
            logic [DIM_W-1:0] c;
            case (op)
                OP_LOAD_A:
                begin
                    r = dim[CFG_A_ROWS];
                    c = dim[CFG_A_COLS];
                end
                OP_LOAD_B:
                begin
                    r = dim[CFG_B_ROWS];
                    c = dim[CFG_B_COLS];
                end
                OP_LOAD_OUT, OP_READ:
                begin
                    r = dim[CFG_OUT_ROWS];
                    c = dim[CFG_OUT_COLS];
                end
                default:
                    return 0;
            endcase
            if (!is_legal_dim(r) || !is_legal_dim(c))
                return 0;
            return int'(r) * int'(c);
        endfunction

        // C += op(A) * op(B), products floored to Q16.16, saturating after every add
        function logic [1:0] apply_gemm(logic fa, logic fb, logic clr);
            int ar, ac, br, bc;
            int i, j, k, ai, bi;
            logic signed [DATA_W-1:0] acc;
            longint prod, total;
            if (!shape_legal())
                return ST_RANGE;
            ar = fa ? int'(dim[CFG_A_COLS]) : int'(dim[CFG_A_ROWS]);
            ac = fa ? int'(dim[CFG_A_ROWS]) : int'(dim[CFG_A_COLS]);
            br = fb ? int'(dim[CFG_B_COLS]) : int'(dim[CFG_B_ROWS]);
            bc = fb ? int'(dim[CFG_B_ROWS]) : int'(dim[CFG_B_COLS]);
            if (ac != br)
                return ST_INNER;
            if (int'(dim[CFG_OUT_ROWS]) != ar || int'(dim[CFG_OUT_COLS]) != bc)
                return ST_SHAPE;
            if (clr)
                foreach (c_mat[n])
                    c_mat[n] = '0;
            for (i = 0; i < ar; i++)
            begin
                for (j = 0; j < bc; j++)
                begin
                    acc = c_mat[i * bc + j];
                    for (k = 0; k < ac; k++)
                    begin
                        ai = fa ? k * int'(dim[CFG_A_COLS]) + i : i * int'(dim[CFG_A_COLS]) + k;
                        bi = fb ? j * int'(dim[CFG_B_COLS]) + k : k * int'(dim[CFG_B_COLS]) + j;
                        prod  = (longint'(a_mat[ai]) * longint'(b_mat[bi])) >>> FRAC_W;
                        total = longint'(acc) + prod;
                        if (total > longint'(Q_MAX))
                            acc = Q_MAX;
                        else if (total < longint'(Q_MIN))
                            acc = Q_MIN;
                        else
                            acc = DATA_W'(total);
                    end
                    c_mat[i * bc + j] = acc;
                end
            end
            return ST_OK;
        endfunction

        function rsp_item_t predict(req_item_t rq);
            rsp_item_t rs;
            int        idx;
            rs.status     = ST_OK;
            rs.read_value = '0;
            idx           = int'(rq.elem_index);
            case (rq.opcode)
                OP_LOAD_A, OP_LOAD_B, OP_LOAD_OUT, OP_READ:
                begin
                    if (idx >= extent(rq.opcode))
                        rs.status = ST_RANGE;
                    else
                    begin
                        case (rq.opcode)
                            OP_LOAD_A:   a_mat[idx] = rq.elem_value;
                            OP_LOAD_B:   b_mat[idx] = rq.elem_value;
                            OP_LOAD_OUT: c_mat[idx] = rq.elem_value;
                            default:     rs.read_value = c_mat[idx];
                        endcase
                    end
                end
                OP_MULTIPLY:
                    rs.status = apply_gemm(rq.flip_a, rq.flip_b, rq.clear_first);
                default:
                    ;
            endcase
            return rs;
        endfunction

        function void note_request(req_item_t rq);
            pending_results.push_back(predict(rq));
        endfunction

        function void check_result(rsp_item_t got);
            rsp_item_t want;
            if (pending_results.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result, status %0d value %08h",
                         $time, got.status, got.read_value);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                failures++;
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, got.status);
            end
            if (got.read_value !== want.read_value)
            begin
                failures++;
                $display("%0t: read_value mismatch, expected %08h actual %08h",
                         $time, want.read_value, got.read_value);
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    req_item_t              req_item;
    logic                   rsp_valid;
    logic                   rsp_stall;
    rsp_item_t              rsp_item;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DIM_W-1:0]       cfg_data;

    gemm_tracker tracker = new();

    int items_sent;
    int req_burst_left;
    int stall_len;
    int free_len;

    matrix_multiply_accumulate uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Result side: check accepted items, then pick the next stall value
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall == 1'b0)
            tracker.check_result(rsp_item);
        if (stall_len == 0 && free_len == 0)
        begin
            case ($urandom_range(0, 99)) inside
                [0:7]:   free_len  = $urandom_range(20, 120);
                [8:54]:  free_len  = $urandom_range(0, 3);
                [55:92]: stall_len = $urandom_range(1, 3);
                default: stall_len = $urandom_range(8, 40);
            endcase
        end
        if (stall_len > 0)
        begin
            stall_len--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            if (free_len > 0)
                free_len--;
            rsp_stall <= 1'b0;
        end
    end

    // Sender gap: mostly none or short, a few long, now and then a burst with no gaps
    function automatic int pick_gap();
        int roll;
        if (req_burst_left > 0)
        begin
            req_burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            req_burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Random Q16.16 value: mostly small, some full range, some extremes
    function automatic logic signed [DATA_W-1:0] rand_q();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        if (roll < 70)
            return $urandom();
        if (roll < 85)
            return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        case ($urandom_range(0, 5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 32'shFFFF_FFFF;
            3:       return 32'sh0000_0000;
            4:       return 32'sh0000_0001;
            default: return 32'sh0001_0000;
        endcase
    endfunction

    function automatic req_item_t make_item(logic [2:0] op, int idx, logic signed [DATA_W-1:0] v,
                                            logic fa, logic fb, logic clr);
        req_item_t it;
        it.opcode      = op;
        it.elem_index  = 8'(idx);
        it.elem_value  = v;
        it.flip_a      = fa;
        it.flip_b      = fb;
        it.clear_first = clr;
        return it;
    endfunction

    function automatic logic [DIM_W-1:0] noise_dim();
        case ($urandom_range(0, 99)) inside
            [0:34]:  return '0;
            [35:69]: return DIM_W'($urandom_range(MAX_DIM + 1, 31));
            default: return DIM_W'($urandom_range(1, 3));
        endcase
    endfunction

    // Present one item and hold it until accepted
    task automatic send_item(input req_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        tracker.note_request(it);
        if (it.opcode <= OP_READ)
            items_sent++;
    endtask

    // Stop sending and wait for every owed result, then let the block settle
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        tracker.set_dim(idx, value);
    endtask

    task automatic set_shape(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                             input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc,
                             input logic [DIM_W-1:0] orows, input logic [DIM_W-1:0] ocols);
        write_reg(CFG_A_ROWS, ar);
        write_reg(CFG_A_COLS, ac);
        write_reg(CFG_B_ROWS, br);
        write_reg(CFG_B_COLS, bc);
        write_reg(CFG_OUT_ROWS, orows);
        write_reg(CFG_OUT_COLS, ocols);
        cfg_we <= 1'b0;
    endtask

    // Fill the whole A and B regions so no multiply can touch an unwritten entry
    task automatic load_operands();
        int n;
        for (n = 0; n < tracker.extent(OP_LOAD_A); n++)
            send_item(make_item(OP_LOAD_A, n, rand_q(), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        for (n = 0; n < tracker.extent(OP_LOAD_B); n++)
            send_item(make_item(OP_LOAD_B, n, rand_q(), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    endtask

    task automatic send_random_item(input logic base_fa, input logic base_fb);
        int        roll;
        int        span;
        req_item_t it;
        roll           = $urandom_range(0, 99);
        it.elem_value  = rand_q();
        it.flip_a      = 1'($urandom_range(0, 1));
        it.flip_b      = 1'($urandom_range(0, 1));
        it.clear_first = ($urandom_range(0, 99) < 30);
        if (roll < 24)
            it.opcode = OP_LOAD_A;
        else if (roll < 38)
            it.opcode = OP_LOAD_B;
        else if (roll < 50)
            it.opcode = OP_LOAD_OUT;
        else if (roll < 74)
            it.opcode = OP_READ;
        else if (roll < 95)
            it.opcode = OP_MULTIPLY;
        else
            it.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        // most multiplies use the flips the phase shape was built for
        if (it.opcode == OP_MULTIPLY && $urandom_range(0, 99) < 65)
        begin
            it.flip_a = base_fa;
            it.flip_b = base_fb;
        end
        span = tracker.extent(it.opcode);
        if (span > 0 && $urandom_range(0, 99) < 85)
            it.elem_index = 8'($urandom_range(0, span - 1));
        else
            it.elem_index = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    // Corners at the reset shape of 1x1: saturation both ways, flooring, range errors
    task automatic run_directed();
        int op;
        send_item(make_item(OP_READ, 0, Q_MAX, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_READ, 255, '0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOAD_A, 0, Q_MAX, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOAD_B, 0, Q_MAX, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_LOAD_A, 1, 32'sh0000_0005, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOAD_B, 255, Q_MIN, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOAD_OUT, 128, Q_MIN, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_MULTIPLY, 0, '0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_READ, 0, '0, 1'b0, 1'b0, 1'b0));
        // large negative product pulls a saturated-high sum down to the floor
        send_item(make_item(OP_LOAD_A, 0, Q_MIN, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_MULTIPLY, 0, '0, 1'b1, 1'b0, 1'b0));
        send_item(make_item(OP_READ, 0, '0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_MULTIPLY, 0, '0, 1'b0, 1'b1, 1'b1));
        send_item(make_item(OP_READ, 0, '0, 1'b0, 1'b0, 1'b0));
        // -1 LSB times 1.0 floors to -1 LSB
        send_item(make_item(OP_LOAD_A, 0, 32'shFFFF_FFFF, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOAD_B, 0, 32'sh0001_0000, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_MULTIPLY, 0, '0, 1'b1, 1'b1, 1'b1));
        send_item(make_item(OP_READ, 0, '0, 1'b0, 1'b0, 1'b0));
        // 1.5 + 2.0 * -0.5
        send_item(make_item(OP_LOAD_OUT, 0, 32'sh0001_8000, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOAD_A, 0, 32'sh0002_0000, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_LOAD_B, 0, 32'shFFFF_8000, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_MULTIPLY, 0, '0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_READ, 0, '0, 1'b0, 1'b0, 1'b0));
        for (op = int'(OP_SPARE_FIRST); op <= int'(OP_SPARE_LAST); op++)
            send_item(make_item(3'(op), 255, Q_MIN, 1'b1, 1'b1, 1'b1));
    endtask

    // One shape setting: program registers while idle, fill A and B if legal, random items
    task automatic run_phase(input int phase_no);
        int               m, k, n, count;
        logic             fa, fb;
        logic [DIM_W-1:0] ar, ac, br, bc, orows, ocols;
        fa = 1'($urandom_range(0, 1));
        fb = 1'($urandom_range(0, 1));
        case (phase_no % 8)
            2:
            begin
                m  = MAX_DIM;
                k  = 1;
                n  = MAX_DIM;
                fa = 1'((phase_no / 8) % 2);
                fb = fa;
            end
            5:
            begin
                m  = $urandom_range(1, 2);
                k  = MAX_DIM;
                n  = $urandom_range(1, 2);
                fa = 1'((phase_no / 8) % 2);
                fb = fa;
            end
            default:
            begin
                m = $urandom_range(1, ($urandom_range(0, 99) < 20) ? 6 : 4);
                k = $urandom_range(1, ($urandom_range(0, 99) < 20) ? 6 : 4);
                n = $urandom_range(1, ($urandom_range(0, 99) < 20) ? 6 : 4);
            end
        endcase
        ar    = DIM_W'(fa ? k : m);
        ac    = DIM_W'(fa ? m : k);
        br    = DIM_W'(fb ? n : k);
        bc    = DIM_W'(fb ? k : n);
        orows = DIM_W'(m);
        ocols = DIM_W'(n);
        // mostly illegal register values, zero or above the maximum; some small legal ones
        if (phase_no % 8 == 3 || phase_no % 8 == 7)
        begin
            ar    = noise_dim();
            ac    = noise_dim();
            br    = noise_dim();
            bc    = noise_dim();
            orows = noise_dim();
            ocols = noise_dim();
        end
        wait_drained();
        set_shape(ar, ac, br, bc, orows, ocols);
        if (tracker.shape_legal())
            load_operands();
        count = $urandom_range(20, 45);
        repeat (count) send_random_item(fa, fb);
    endtask

    initial
    begin
        int phase_no;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_item       = '0;
        rsp_stall      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        items_sent     = 0;
        req_burst_left = 0;
        stall_len      = 0;
        free_len       = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            run_phase(phase_no);
            phase_no++;
        end
        wait_drained();

        if (tracker.failures == 0 && tracker.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/mma_pkg.sv
rtl/mma_mac.sv
rtl/matrix_multiply_accumulate.sv
rtl/mma_check.sv
verif/matrix_multiply_accumulate_tb.sv
